// ===== sv/b64d_pkg.sv =====
// Shared types, constants and the alphabet lookup for the LSB-first base64 decoder.
// No dependencies; every other file imports this package.
package b64d_pkg;

  // Default depth of the queue between the front and back parts
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Character codes
  localparam logic [7:0] PAD_CODE   = 8'h3D;
  localparam logic [7:0] UPPER_A    = 8'h41;
  localparam logic [7:0] UPPER_Z    = 8'h5A;
  localparam logic [7:0] LOWER_A    = 8'h61;
  localparam logic [7:0] LOWER_Z    = 8'h7A;
  localparam logic [7:0] DIGIT_0    = 8'h30;
  localparam logic [7:0] DIGIT_9    = 8'h39;
  localparam logic [7:0] PLUS_CODE  = 8'h2B;
  localparam logic [7:0] SLASH_CODE = 8'h2F;

  // Sextet values
  localparam logic [5:0] LOWER_BASE = 6'd26;
  localparam logic [5:0] DIGIT_BASE = 6'd52;
  localparam logic [5:0] PLUS_VAL   = 6'd62;
  localparam logic [5:0] SLASH_VAL  = 6'd63;

  // One classified character as it waits in the queue
  typedef struct packed {
    logic [5:0] sextet;
    logic       bad;
    logic       pad;
    logic       last;
  } b64d_entry_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } b64d_qstat_t;

  // Alphabet lookup: bit 6 flags a character outside the alphabet
  function automatic logic [6:0] b64d_map(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      d = c - UPPER_A;
      return {1'b0, d[5:0]};
    end
    if (c >= LOWER_A && c <= LOWER_Z) begin
      d = c - LOWER_A;
      return {1'b0, d[5:0] + LOWER_BASE};
    end
    if (c >= DIGIT_0 && c <= DIGIT_9) begin
      d = c - DIGIT_0;
      return {1'b0, d[5:0] + DIGIT_BASE};
    end
    if (c == PLUS_CODE) return {1'b0, PLUS_VAL};
    if (c == SLASH_CODE) return {1'b0, SLASH_VAL};
    return 7'b100_0000;
  endfunction

endpackage

// ===== sv/b64d_front.sv =====
// Front part: takes input requests and classifies each character for the queue.
// Depends on b64d_pkg.
module b64d_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic [7:0]            in_char_code,
  input  logic                  in_last_char,
  output logic                  in_stall,
  input  b64d_pkg::b64d_qstat_t q_stat,
  output logic                  push,
  output b64d_pkg::b64d_entry_t push_entry
);
  import b64d_pkg::*;

  logic [6:0] mapped;

  // Back-pressure comes straight from the queue
  assign in_stall = q_stat.full;
  assign push     = in_valid && !q_stat.full;

  // Classify: sextet value, bad flag, pad marker, end of message
  always_comb begin
    mapped                = b64d_map(in_char_code);
    push_entry.sextet     = mapped[5:0];
    push_entry.pad        = (in_char_code == PAD_CODE);
    push_entry.bad        = mapped[6] && (in_char_code != PAD_CODE);
    push_entry.last       = in_last_char;
  end

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push) else $error("front pushed into a full queue");
  a_pad_not_bad: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.pad |-> !push_entry.bad) else $error("pad flagged bad");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.bad |-> push_entry.sextet == 6'd0)
    else $error("bad character has non-zero sextet");
`endif

endmodule

// ===== sv/b64d_queue.sv =====
// Short FIFO of classified characters between front and back parts.
// Depends on b64d_pkg.
module b64d_queue #(
  parameter int unsigned DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  b64d_pkg::b64d_entry_t push_entry,
  input  logic                  pop,
  output b64d_pkg::b64d_entry_t head_entry,
  output b64d_pkg::b64d_qstat_t q_stat
);
  import b64d_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  b64d_entry_t      slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign q_stat.full  = (count_r == CNT_FULL);
  assign q_stat.empty = (count_r == '0);
  assign head_entry   = slots_r[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Slot storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= push_entry;
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL) else $error("queue count out of range");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> !pop) else $error("pop from empty queue");
  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + 1'b1)
    else $error("push did not grow the queue");
`endif

endmodule

// ===== sv/b64d_back.sv =====
// Back part: packs sextets LSB first into bytes and holds the output register.
// Depends on b64d_pkg.
module b64d_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  b64d_pkg::b64d_qstat_t q_stat,
  input  b64d_pkg::b64d_entry_t head_entry,
  output logic                  pop,
  output logic                  out_valid,
  output logic [7:0]            out_data_byte,
  output logic                  out_bad_char,
  input  logic                  out_stall
);
  import b64d_pkg::*;

  logic [7:0]  acc_r, acc_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        pad_r, pad_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  data_r, data_nxt;
  logic        bad_r, bad_nxt;
  logic [15:0] merged;
  logic        emit;
  logic        out_free;

  assign out_valid     = out_valid_r;
  assign out_data_byte = data_r;
  assign out_bad_char  = bad_r;

  // Merge the sextet at the current bit position
  always_comb begin
    merged   = {8'h00, acc_r} | ({10'h000, head_entry.sextet} << cnt_r);
    emit     = !pad_r && !head_entry.pad && (cnt_r >= 3'd2);
    out_free = !out_valid_r || !out_stall;
    // an item that makes no byte may pass while the output is held
    pop      = !q_stat.empty && (out_free || !emit);
  end

  // Next state of the packer and output register
  always_comb begin
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    pad_nxt       = pad_r;
    data_nxt      = data_r;
    bad_nxt       = bad_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (pop) begin
      if (!pad_r) begin
        if (head_entry.pad) begin
          pad_nxt = 1'b1;
        end else begin
          cnt_nxt = cnt_r + 3'd6;
          if (emit) begin
            acc_nxt       = merged[15:8];
            data_nxt      = merged[7:0];
            bad_nxt       = head_entry.bad;
            out_valid_nxt = 1'b1;
          end else begin
            acc_nxt = merged[7:0];
          end
        end
      end
      // end of message drops partial bits
      if (head_entry.last) begin
        acc_nxt = 8'h00;
        cnt_nxt = 3'd0;
        pad_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= 8'h00;
      cnt_r       <= 3'd0;
      pad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      pad_r       <= pad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    bad_r  <= bad_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_even: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r[0] == 1'b0) else $error("bit count went odd");
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    pop && emit |=> out_valid_r) else $error("emitted byte not presented");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    pop && head_entry.last |=> (cnt_r == 3'd0) && !pad_r && (acc_r == 8'h00))
    else $error("end of message did not clear state");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(pop && emit))
    else $error("held output overwritten");
`endif

endmodule

// ===== sv/base64_lsb_first_decoder.sv =====
// Top level of the LSB-first base64 decoder: front, queue and back parts.
// Depends on b64d_pkg, b64d_front, b64d_queue, b64d_back.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in_     | input     | in_valid / in_stall  | in_char_code[7:0], in_last_char
//  out_    | output    | out_valid / out_stall| out_data_byte[7:0], out_bad_char
//
// One character request per cycle is taken while in_stall is low; the back part's
// packer updates its accumulator as items are popped, so the sustained rate is one
// item a cycle while the output is not stalled. A completing character is held in a
// queue slot, then its byte in the output register. Reset is synchronous, active
// low, and clears all control state. A stalled output holds its byte; characters
// that complete no byte keep draining, and in_stall rises only once the queue has filled.
module base64_lsb_first_decoder #(
  parameter int unsigned QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [7:0] in_char_code,
  input  logic       in_last_char,
  output logic       in_stall,
  output logic       out_valid,
  output logic [7:0] out_data_byte,
  output logic       out_bad_char,
  input  logic       out_stall
);
  import b64d_pkg::*;

  b64d_qstat_t q_stat;
  b64d_entry_t push_entry;
  b64d_entry_t head_entry;
  logic        push;
  logic        pop;

  // Accept and classify
  b64d_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .in_stall     (in_stall),
    .q_stat       (q_stat),
    .push         (push),
    .push_entry   (push_entry)
  );

  // Decoupling queue
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head_entry (head_entry),
    .q_stat     (q_stat)
  );

  // Bit packing and output
  b64d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_stat        (q_stat),
    .head_entry    (head_entry),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_data_byte (out_data_byte),
    .out_bad_char  (out_bad_char),
    .out_stall     (out_stall)
  );

endmodule

// ===== verif/b64d_checker.sv =====
// Checker for the LSB-first base64 decoder: watches both channels, predicts the bytes
// and compares them with what the block emits. Depends on b64d_pkg.
`timescale 1ns / 100ps

module b64d_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_last_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_data_byte,
  input  logic        out_bad_char,
  output int unsigned fail_count,
  output int unsigned bytes_pending
);
  import b64d_pkg::*;

  localparam int unsigned REPORT_MAX = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       bad;
  } decoded_byte_t;

  decoded_byte_t byte_fifo[$];
  decoded_byte_t got;
  decoded_byte_t want;
  decoded_byte_t made;

  // Predictor state
  logic [7:0]  acc;
  logic [2:0]  bit_cnt;
  logic        pad_hold;
  logic [6:0]  look;
  logic [15:0] merged;

  // Alphabet lookup: {outside alphabet, six-bit value}
  function automatic logic [6:0] classify_char(input logic [7:0] c);
    logic [7:0] off;
    off = 8'h00;
    if (c >= UPPER_A && c <= UPPER_Z) begin
      off = c - UPPER_A;
      return {1'b0, off[5:0]};
    end else if (c >= LOWER_A && c <= LOWER_Z) begin
      off = c - LOWER_A + {2'b00, LOWER_BASE};
      return {1'b0, off[5:0]};
    end else if (c >= DIGIT_0 && c <= DIGIT_9) begin
      off = c - DIGIT_0 + {2'b00, DIGIT_BASE};
      return {1'b0, off[5:0]};
    end else if (c == PLUS_CODE) begin
      return {1'b0, PLUS_VAL};
    end else if (c == SLASH_CODE) begin
      return {1'b0, SLASH_VAL};
    end
    return {1'b1, 6'd0};
  endfunction

  task automatic note_failure(input string what);
    if (fail_count < REPORT_MAX) $display("%t mismatch: %s", $realtime, what);
    fail_count = fail_count + 1;
  endtask

  initial begin
    fail_count = 0;
    bytes_pending = 0;
    acc = 8'h00;
    bit_cnt = 3'd0;
    pad_hold = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      acc = 8'h00;
      bit_cnt = 3'd0;
      pad_hold = 1'b0;
      byte_fifo.delete();
    end else begin
      // Emitted byte against the oldest prediction
      if (out_valid && !out_stall) begin
        got = '{data: out_data_byte, bad: out_bad_char};
        if (byte_fifo.size() == 0) begin
          note_failure($sformatf("unexpected byte %h bad %b", got.data, got.bad));
        end else begin
          want = byte_fifo.pop_front();
          if (got.data !== want.data)
            note_failure($sformatf("data_byte expected %h actual %h", want.data, got.data));
          if (got.bad !== want.bad)
            note_failure($sformatf("bad_char expected %b actual %b", want.bad, got.bad));
        end
      end

      // Character request: advance the predictor
      if (in_valid && !in_stall) begin
        if (!pad_hold) begin
          if (in_char_code == PAD_CODE) begin
            pad_hold = 1'b1;
          end else begin
            look = classify_char(in_char_code);
            merged = {8'h00, acc} | ({10'd0, look[5:0]} << bit_cnt);
            if (bit_cnt >= 3'd2) begin
              made = '{data: merged[7:0], bad: look[6]};
              byte_fifo = {byte_fifo, made};
              acc = merged[15:8];
              bit_cnt = bit_cnt - 3'd2;
            end else begin
              acc = merged[7:0];
              bit_cnt = bit_cnt + 3'd6;
            end
          end
        end
        // End of message drops partial bits
        if (in_last_char) begin
          acc = 8'h00;
          bit_cnt = 3'd0;
          pad_hold = 1'b0;
        end
      end
    end
    bytes_pending = byte_fifo.size();
  end

endmodule

// ===== verif/base64_lsb_first_decoder_tb.sv =====
// Testbench top for the LSB-first base64 decoder: clock, reset, character stimulus,
// output back-pressure and the verdict. Depends on b64d_pkg, b64d_checker and the block.
`timescale 1ns / 100ps

module base64_lsb_first_decoder_tb;
  import b64d_pkg::*;

  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_WAIT  = 8;
  localparam int unsigned RANDOM_ITEMS = 600;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic [7:0] in_char_code;
  logic       in_last_char;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_data_byte;
  logic       out_bad_char;
  logic       out_stall;

  int unsigned fail_count;
  int unsigned bytes_pending;
  int unsigned chars_sent;
  bit          no_idle;
  bit          hold_long;

  base64_lsb_first_decoder dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_data_byte(out_data_byte),
    .out_bad_char (out_bad_char),
    .out_stall    (out_stall)
  );

  b64d_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_char_code (in_char_code),
    .in_last_char (in_last_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data_byte(out_data_byte),
    .out_bad_char (out_bad_char),
    .fail_count   (fail_count),
    .bytes_pending(bytes_pending)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog
  initial begin
    #400000;
    $display("status: fail");
    $finish;
  end

  // Character for a six-bit value
  function automatic logic [7:0] alpha_char(input logic [5:0] v);
    if (v < LOWER_BASE) return UPPER_A + {2'b00, v};
    if (v < DIGIT_BASE) return LOWER_A + {2'b00, v - LOWER_BASE};
    if (v < PLUS_VAL) return DIGIT_0 + {2'b00, v - DIGIT_BASE};
    if (v == PLUS_VAL) return PLUS_CODE;
    return SLASH_CODE;
  endfunction

  // One character request, with an optional idle burst in front
  task automatic send_char(input logic [7:0] c, input logic last);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= c;
    in_last_char <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Message: body characters, then pads, then characters after the pad
  task automatic send_message(input int unsigned len, input int unsigned pads,
                              input int unsigned tail, input bit noisy);
    int unsigned total;
    int unsigned n;
    logic [7:0]  c;
    total = len + pads + tail;
    for (n = 0; n < total; n++) begin
      if (n >= len && n < len + pads) c = PAD_CODE;
      else if (n >= len + pads || (noisy && $urandom_range(0, 2) == 0))
        c = 8'($urandom_range(0, 255));
      else c = alpha_char(6'($urandom_range(0, 63)));
      send_char(c, n == total - 1);
    end
    chars_sent = chars_sent + total;
  endtask

  // Mostly well-formed messages, some noise and some broken by an early pad
  task automatic run_random(input int unsigned count);
    int unsigned goal;
    int unsigned kind;
    goal = chars_sent + count;
    while (chars_sent < goal) begin
      kind = $urandom_range(0, 9);
      if (kind == 0)
        send_message($urandom_range(1, 12), 0, 0, 1'b1);
      else if (kind == 1)
        send_message($urandom_range(1, 8), 1, $urandom_range(1, 4), 1'b0);
      else
        send_message($urandom_range(1, 16),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0, 0, 1'b0);
    end
  endtask

  // Output back-pressure
  initial begin
    out_stall <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  // Stimulus and verdict
  initial begin
    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_char_code <= 8'h00;
    in_last_char <= 1'b0;
    chars_sent   = 0;
    no_idle      = 1'b0;
    hold_long    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all ones
    send_char(SLASH_CODE, 1'b0);
    send_char(SLASH_CODE, 1'b0);
    send_char(SLASH_CODE, 1'b0);
    send_char(SLASH_CODE, 1'b1);
    // Range ends of the letters, digits and symbols
    send_char(UPPER_A, 1'b0);
    send_char(UPPER_Z, 1'b0);
    send_char(LOWER_A, 1'b0);
    send_char(LOWER_Z, 1'b1);
    send_char(DIGIT_0, 1'b0);
    send_char(DIGIT_9, 1'b0);
    send_char(PLUS_CODE, 1'b0);
    send_char(SLASH_CODE, 1'b1);
    // Characters outside the alphabet, with and without a completed byte
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h80, 1'b0);
    send_char(8'h7F, 1'b1);
    // Pad stops decoding; later characters ignored until the last
    send_char(alpha_char(6'd16), 1'b0);
    send_char(PAD_CODE, 1'b0);
    send_char(alpha_char(6'd49), 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(PAD_CODE, 1'b1);
    // Single-character messages: lone pad, and partial bits dropped
    send_char(PAD_CODE, 1'b1);
    send_char(alpha_char(6'd32), 1'b1);

    run_random(RANDOM_ITEMS / 2);

    // Long receiver hold-off while characters keep coming
    no_idle   = 1'b1;
    hold_long = 1'b1;
    run_random(60);
    no_idle = 1'b0;

    run_random(RANDOM_ITEMS / 3 - 60);

    // Final part runs without idling
    no_idle = 1'b1;
    run_random(RANDOM_ITEMS - RANDOM_ITEMS / 2 - RANDOM_ITEMS / 3);
    in_valid <= 1'b0;

    @(posedge clk);
    while (bytes_pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/b64d_pkg.sv
sv/b64d_front.sv
sv/b64d_queue.sv
sv/b64d_back.sv
sv/base64_lsb_first_decoder.sv
verif/b64d_checker.sv
verif/base64_lsb_first_decoder_tb.sv
